// ===== rtl/core/sprite_rle_frame_decoder_macros.svh =====
// Assertion macros shared by the sprite frame decoder RTL.
`ifndef SPRITE_RLE_FRAME_DECODER_MACROS_SVH
`define SPRITE_RLE_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SRLE_ASSERT_NOW(label, clock, reset, cond, conseq, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SRLE_ASSERT_NEXT(label, clock, reset, cond, conseq, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== rtl/core/srle_pkg.sv =====
// Types and constants of the run-length sprite frame decoder.
package srle_pkg;

  // Default largest frame dimension accepted without error.
  localparam int MAX_DIM_DEF = 1024;

  // Field and state widths.
  localparam int DIM_W   = 11;
  localparam int POS_W   = 10;
  localparam int LEN_W   = 24;
  localparam int BYTE_W  = 8;
  localparam int LIT_W   = 7;
  localparam int IDX_W   = 2;
  localparam int CFG_W   = 24;

  // Command codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] CFG_FRAME_LENGTH = 2'd2;

  // Coded byte that ends a row; the column saturates at its all-ones value.
  localparam logic [BYTE_W-1:0] ROW_END = 8'h80;
  localparam logic [DIM_W-1:0]  COL_MAX = 11'h7ff;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    logic [DIM_W-1:0] column;
    logic [DIM_W-1:0] row;
    logic             row_underflow;
    logic [LIT_W-1:0] literal_left;
    logic [LEN_W-1:0] bytes_seen;
    logic             error_latch;
  } state_t;

  // One result item.
  typedef struct packed {
    logic              pixel_valid;
    logic [POS_W-1:0]  pixel_x;
    logic [POS_W-1:0]  pixel_y;
    logic [BYTE_W-1:0] color_index;
    logic              position_error;
    logic              frame_end;
  } result_t;

endpackage

// ===== rtl/core/srle_step.sv =====
// Decode step: next decoder state and result for one coded item.
module srle_step import srle_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic [DIM_W-1:0]  frame_width,
  input  logic [DIM_W-1:0]  frame_height,
  input  logic [LEN_W-1:0]  frame_length,
  input  state_t            st,
  input  logic              cmd,
  input  logic [BYTE_W-1:0] code_byte,
  output state_t            st_next,
  output result_t           res
);

  logic [LIT_W-1:0] col_addend;
  logic [DIM_W:0]   col_sum;
  logic [DIM_W-1:0] col_sat;
  logic [LEN_W-1:0] count_next;
  logic             oversize;
  logic             outside;

  // Saturating column advance: one for a literal, the low bits for a skip.
  assign col_addend = (st.literal_left != '0) ? LIT_W'(1) : code_byte[LIT_W-1:0];
  assign col_sum    = {1'b0, st.column} + {{(DIM_W+1-LIT_W){1'b0}}, col_addend};
  assign col_sat    = col_sum[DIM_W] ? COL_MAX : col_sum[DIM_W-1:0];

  assign count_next = st.bytes_seen + LEN_W'(1);
  assign oversize   = (32'(frame_width) > 32'(MAX_DIM)) || (32'(frame_height) > 32'(MAX_DIM));
  assign outside    = st.row_underflow || (st.row >= frame_height) ||
                      (st.column >= frame_width);

  // Command and byte decode.
  always_comb begin
    st_next = st;
    res     = '0;
    if (cmd == CMD_START) begin
      st_next.column       = '0;
      st_next.literal_left = '0;
      st_next.bytes_seen   = '0;
      st_next.error_latch  = oversize;
      if (frame_height == '0) begin
        st_next.row           = '0;
        st_next.row_underflow = 1'b1;
      end else begin
        st_next.row           = frame_height - DIM_W'(1);
        st_next.row_underflow = 1'b0;
      end
    end else if (st.bytes_seen < frame_length) begin
      st_next.bytes_seen = count_next;
      res.frame_end      = (count_next == frame_length);
      if (st.literal_left != '0) begin
        st_next.literal_left = st.literal_left - LIT_W'(1);
        if (outside) begin
          st_next.error_latch = 1'b1;
        end else if (!st.error_latch) begin
          res.pixel_valid = 1'b1;
          res.pixel_x     = st.column[POS_W-1:0];
          res.pixel_y     = st.row[POS_W-1:0];
          res.color_index = code_byte;
        end
        st_next.column = col_sat;
      end else if (code_byte == ROW_END) begin
        st_next.column = '0;
        if (!st.row_underflow) begin
          if (st.row == '0) begin
            st_next.row_underflow = 1'b1;
          end else begin
            st_next.row = st.row - DIM_W'(1);
          end
        end
      end else if (code_byte[BYTE_W-1]) begin
        st_next.column = col_sat;
      end else begin
        st_next.literal_left = code_byte[LIT_W-1:0];
      end
    end
    res.position_error = st_next.error_latch;
  end

endmodule

// ===== rtl/core/sprite_rle_frame_decoder.sv =====
// Top level of the run-length sprite frame decoder.
//
// Input channel (in_valid/in_ready) carries one item: cmd 0 starts a frame,
// cmd 1 delivers one coded byte in code_byte. Output channel
// (out_valid/out_ready) returns exactly one result item per input item:
// an optional pixel write, the latched position error and the frame-end flag.
// Frame width, height and length are to be written through cfg_we/cfg_index/cfg_data
// only while the decoder is idle; the block itself does not enforce this.
// An accepted item is held in an input register; when the result register is free
// or draining, the decode logic updates the frame state and loads the result
// register. One item per cycle is sustained while the receiver accepts results;
// the rate is set by the state update between input and result registers.
// If the receiver stalls, the result register holds and the input register
// fills; in_ready drops only when both are full.
// Reset clears the frame state, the configuration registers and both valid
// flags; no clearing pass is needed.
module sprite_rle_frame_decoder import srle_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [BYTE_W-1:0] code_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              pixel_valid,
  output logic [POS_W-1:0]  pixel_x,
  output logic [POS_W-1:0]  pixel_y,
  output logic [BYTE_W-1:0] color_index,
  output logic              position_error,
  output logic              frame_end
);

`include "sprite_rle_frame_decoder_macros.svh"

  logic [DIM_W-1:0]  frame_width;
  logic [DIM_W-1:0]  frame_height;
  logic [LEN_W-1:0]  frame_length;
  logic              s1_valid;
  logic              s1_cmd;
  logic [BYTE_W-1:0] s1_byte;
  logic              advance;
  state_t            st;
  state_t            st_next;
  result_t           res;
  result_t           out_res;

  // The held item moves on when the result register is free or draining.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  srle_step #(
    .MAX_DIM(MAX_DIM)
  ) u_step (
    .frame_width (frame_width),
    .frame_height(frame_height),
    .frame_length(frame_length),
    .st          (st),
    .cmd         (s1_cmd),
    .code_byte   (s1_byte),
    .st_next     (st_next),
    .res         (res)
  );

  // Control state, configuration and decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      st           <= '0;
      frame_width  <= '0;
      frame_height <= '0;
      frame_length <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        st        <= st_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
          CFG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
          CFG_FRAME_LENGTH: frame_length <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers of the input and result stages.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd  <= cmd;
      s1_byte <= code_byte;
    end
    if (advance) begin
      out_res <= res;
    end
  end

  assign pixel_valid    = out_res.pixel_valid;
  assign pixel_x        = out_res.pixel_x;
  assign pixel_y        = out_res.pixel_y;
  assign color_index    = out_res.color_index;
  assign position_error = out_res.position_error;
  assign frame_end      = out_res.frame_end;

  // The error flag only clears on a start command.
  `SRLE_ASSERT_NEXT(a_error_sticky, clk, rst, st.error_latch && !(advance && s1_cmd == CMD_START), st.error_latch, "error latch cleared without a start command")
  // A delivered pixel never comes with the error flag raised.
  `SRLE_ASSERT_NOW(a_pixel_no_error, clk, rst, out_valid && pixel_valid, !position_error, "pixel written while position error is set")
  // Once the row has gone past the top, the row index rests at zero.
  `SRLE_ASSERT_NOW(a_underflow_row, clk, rst, st.row_underflow, st.row == '0, "row underflow with nonzero row")

endmodule
